// ----- src/shs_pkg.sv -----
// shared types and constants for the streaming sha-256 hasher
// used by shs_ctrl, shs_datapath and sha256_stream_hasher; no dependencies
package shs_pkg;

  // input commands
  localparam logic [1:0] CMD_ABSORB      = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FIN  = 2'd1;
  localparam logic [1:0] CMD_FINISH      = 2'd2;

  // source of the byte shifted into the block buffer
  localparam logic [1:0] BSEL_INPUT = 2'd0;
  localparam logic [1:0] BSEL_PAD80 = 2'd1;
  localparam logic [1:0] BSEL_ZERO  = 2'd2;
  localparam logic [1:0] BSEL_LEN   = 2'd3;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [7:0][31:0] INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // controller to datapath
  typedef struct packed {
    logic       shift_en;
    logic [1:0] byte_sel;
    logic       count_inc;
    logic       load_work;
    logic       round_en;
    logic       add_hash;
    logic       out_adv;
    logic       reinit;
  } shs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       out_last;
  } shs_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    unique case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ----- src/shs_datapath.sv -----
// datapath: block buffer / schedule window, round unit, hash state, counters
// depends on shs_pkg
module shs_datapath (
  input  logic              clk,
  input  logic              rst,
  input  shs_pkg::shs_cmd_t cmd,
  input  logic [7:0]        data_byte,
  output shs_pkg::shs_stat_t stat,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index
);

  logic [15:0][31:0] win;     // w[0] oldest; doubles as the byte buffer
  logic [7:0][31:0]  work;    // a..h
  logic [7:0][31:0]  hash;
  logic [60:0]       count;   // message bytes, bit count is count * 8
  logic [5:0]        fill;
  logic [5:0]        rnd;
  logic [2:0]        out_idx;

  logic [63:0] bit_total;
  logic [7:0]  len_byte;
  logic [7:0]  shift_byte;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign bit_total = {count, 3'b000};
  // big-endian length byte for offsets 56..63
  assign len_byte  = bit_total[{~fill[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd.byte_sel)
      shs_pkg::BSEL_INPUT: shift_byte = data_byte;
      shs_pkg::BSEL_PAD80: shift_byte = shs_pkg::PAD_BYTE;
      shs_pkg::BSEL_ZERO:  shift_byte = 8'h00;
      shs_pkg::BSEL_LEN:   shift_byte = len_byte;
      default:             shift_byte = 8'h00;
    endcase
  end

  assign w_new = shs_pkg::small_sigma1(win[14]) + win[9] +
                 shs_pkg::small_sigma0(win[1]) + win[0];

  assign t1 = work[7] + shs_pkg::big_sigma1(work[4]) +
              ((work[4] & work[5]) ^ (~work[4] & work[6])) +
              shs_pkg::round_k(rnd) + win[0];
  assign t2 = shs_pkg::big_sigma0(work[0]) +
              ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));

  // window: bytes enter at the bottom, rounds shift out whole words
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= {win[k][23:0], win[k+1][31:24]};
      end
      win[15] <= {win[15][23:0], shift_byte};
    end else if (cmd.round_en) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= win[k+1];
      end
      win[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      work <= hash;
    end else if (cmd.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash    <= shs_pkg::INIT_HASH;
      count   <= '0;
      fill    <= '0;
      rnd     <= '0;
      out_idx <= '0;
    end else begin
      if (cmd.reinit) begin
        hash  <= shs_pkg::INIT_HASH;
        count <= '0;
      end else begin
        if (cmd.add_hash) begin
          for (int k = 0; k < 8; k++) begin
            hash[k] <= hash[k] + work[k];
          end
        end
        if (cmd.count_inc) begin
          count <= count + 61'd1;
        end
      end
      if (cmd.shift_en) begin
        fill <= fill + 6'd1;
      end
      if (cmd.load_work) begin
        rnd <= '0;
      end else if (cmd.round_en) begin
        rnd <= rnd + 6'd1;
      end
      if (cmd.out_adv) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  assign stat.fill       = fill;
  assign stat.round_last = (rnd == shs_pkg::ROUND_LAST);
  assign stat.out_last   = (out_idx == shs_pkg::WORD_LAST);
  assign digest_word     = hash[out_idx];
  assign word_index      = out_idx;

endmodule

// ----- src/shs_ctrl.sv -----
// controller: sequences absorb, padding, compression and digest output
// depends on shs_pkg
module shs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         command,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  shs_pkg::shs_stat_t stat,
  output shs_pkg::shs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_PAD80 = 3'd4;
  localparam logic [2:0] S_PADZ  = 3'd5;
  localparam logic [2:0] S_LEN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] ret, ret_next;   // where to go after a compression
  logic       fill_full;

  assign fill_full = (stat.fill == shs_pkg::FILL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (command)
            shs_pkg::CMD_ABSORB: begin
              cmd.shift_en  = 1'b1;
              cmd.byte_sel  = shs_pkg::BSEL_INPUT;
              cmd.count_inc = 1'b1;
              if (fill_full) begin
                state_next = S_LOAD;
                ret_next   = S_IDLE;
              end
            end
            shs_pkg::CMD_ABSORB_FIN: begin
              cmd.shift_en  = 1'b1;
              cmd.byte_sel  = shs_pkg::BSEL_INPUT;
              cmd.count_inc = 1'b1;
              if (fill_full) begin
                state_next = S_LOAD;
                ret_next   = S_PAD80;
              end else begin
                state_next = S_PAD80;
              end
            end
            shs_pkg::CMD_FINISH: begin
              state_next = S_PAD80;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = shs_pkg::BSEL_PAD80;
        if (fill_full) begin
          state_next = S_LOAD;
          ret_next   = S_PADZ;
        end else begin
          state_next = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.fill == shs_pkg::LEN_OFFSET) begin
          state_next = S_LEN;
        end else begin
          cmd.shift_en = 1'b1;
          cmd.byte_sel = shs_pkg::BSEL_ZERO;
          if (fill_full) begin
            state_next = S_LOAD;
            ret_next   = S_PADZ;
          end
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = shs_pkg::BSEL_LEN;
        if (fill_full) begin
          state_next = S_LOAD;
          ret_next   = S_OUT;
        end
      end
      S_LOAD: begin
        cmd.load_work = 1'b1;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_hash = 1'b1;
        state_next   = ret;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_adv = 1'b1;
          if (stat.out_last) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/sha256_stream_hasher.sv -----
// an absorbed byte is shifted into the block buffer; the 64th byte of a block starts a
// compression (load, 64 rounds on one shared round unit, hash add)
// finish: pad byte 0x80, zero bytes up to offset 56, then the length bytes, one or two
// compressions, then 8 digest items; one item is worked on at a time
// throughput is 1 byte per cycle, but no input is taken while padding, compressing or sending the digest
// reset (rst, synchronous): hash state to initial values, bit count and fill to zero, idle
// top level of the streaming sha-256 hasher; depends on shs_pkg, shs_ctrl, shs_datapath
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // command [1:0], data_byte [9:2], zeros above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zeros above
  output logic        m_tlast    // last_word
);

  shs_pkg::shs_cmd_t  cmd;
  shs_pkg::shs_stat_t stat;
  logic [31:0]        digest_word;
  logic [2:0]         word_index;

  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .command   (s_tdata[1:0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_tdata[9:2]),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign m_tdata = {5'b00000, word_index, digest_word};
  assign m_tlast = stat.out_last;

  // input and output never open at once
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input accepted while digest pending");

  // after the final digest item the block takes input again
  a_back: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after last digest item");

  // digest goes out only after the padded message filled whole blocks
  a_fill: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (stat.fill == 6'd0))
    else $error("digest with partial block");

  // rounds never overlap the byte buffer shifting
  a_round: assert property (@(posedge clk) disable iff (rst) !(cmd.round_en && cmd.shift_en))
    else $error("shift during compression");

endmodule

// ----- dv/sha256_stream_hasher_tb.sv -----
// self-checking testbench for the streaming sha-256 hasher: drives byte and finish items,
// predicts every digest word and checks the output stream in order
// depends on shs_pkg and sha256_stream_hasher
module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_CYCLES = 150;
  localparam int         HOLD_CYCLES = 400;
  localparam int         RANDOM_ITEMS = 280;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_word_t;

  class digest_scoreboard;
    bit [31:0]    rc [64];
    bit [31:0]    iv [8];
    bit [31:0]    hash [8];
    bit [7:0]     blk [64];
    bit [63:0]    bit_total;
    digest_word_t words_due [$];
    int           errors;
    int           words_checked;
    int           digests_predicted;

    function new();
      rc = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      iv = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };
      hash = iv;
      bit_total = '0;
      errors = 0;
      words_checked = 0;
      digests_predicted = 0;
    endfunction

    function bit [31:0] rot(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function bit [31:0] sum0(bit [31:0] x);
      return rot(x, 2) ^ rot(x, 13) ^ rot(x, 22);
    endfunction

    function bit [31:0] sum1(bit [31:0] x);
      return rot(x, 6) ^ rot(x, 11) ^ rot(x, 25);
    endfunction

    function bit [31:0] sched0(bit [31:0] x);
      return rot(x, 7) ^ rot(x, 18) ^ (x >> 3);
    endfunction

    function bit [31:0] sched1(bit [31:0] x);
      return rot(x, 17) ^ rot(x, 19) ^ (x >> 10);
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1;
      bit [31:0] t2;
      int        t;
      for (t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (t = 16; t < 64; t++)
        w[t] = sched1(w[t-2]) + w[t-7] + sched0(w[t-15]) + w[t-16];
      v = hash;
      for (t = 0; t < 64; t++) begin
        t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + rc[t] + w[t];
        t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (t = 0; t < 8; t++)
        hash[t] = hash[t] + v[t];
    endfunction

    function void take_byte(bit [7:0] b);
      int pos;
      pos = int'(bit_total[8:3]);
      blk[pos] = b;
      bit_total = bit_total + 64'd8;
      if (pos == 63)
        compress();
    endfunction

    // pad, length, final compression(s), then queue the eight digest words
    function void close_message();
      int           pos;
      int           k;
      bit [63:0]    total;
      digest_word_t dw;
      pos = int'(bit_total[8:3]);
      total = bit_total;
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      for (k = 0; k < 8; k++)
        blk[56+k] = total[63-8*k -: 8];
      compress();
      for (k = 0; k < 8; k++) begin
        dw.word = hash[k];
        dw.index = 3'(k);
        dw.last = (k == 7);
        words_due.push_back(dw);
      end
      hash = iv;
      bit_total = '0;
      digests_predicted++;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] b);
      case (cmd)
        shs_pkg::CMD_ABSORB: begin
          take_byte(b);
        end
        shs_pkg::CMD_ABSORB_FIN: begin
          take_byte(b);
          close_message();
        end
        shs_pkg::CMD_FINISH: begin
          close_message();
        end
        default: begin
        end
      endcase
    endfunction

    task flag(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t dw;
      words_checked++;
      if (words_due.size() == 0) begin
        flag($sformatf("unexpected digest word %08h index %0d", word, index));
      end else begin
        dw = words_due.pop_front();
        if (word !== dw.word)
          flag($sformatf("digest word %08h, expected %08h", word, dw.word));
        if (index !== dw.index)
          flag($sformatf("word index %0d, expected %0d", index, dw.index));
        if (last !== dw.last)
          flag($sformatf("last flag %0b, expected %0b", last, dw.last));
      end
    endtask

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_scoreboard sb;
  int   tx_idle_pct = 14;
  int   rx_idle_pct = 65;
  logic rx_hold = 1'b0;
  logic pressure_go = 1'b0;
  int   items_sent = 0;
  int   messages_sent = 0;
  int   cycles = 0;

  sha256_stream_hasher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: check accepted words, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
      if (rx_hold)
        m_tready <= 1'b0;
      else
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // long output stall so the block backs up and stops taking items
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, b, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(cmd, b);
    if (cmd != CMD_UNUSED)
      items_sent++;
    if (cmd == shs_pkg::CMD_ABSORB_FIN || cmd == shs_pkg::CMD_FINISH)
      messages_sent++;
  endtask

  task automatic send_message(input int len);
    bit fin_on_byte;
    int i;
    fin_on_byte = (len > 0) && $urandom_range(0, 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
      if (fin_on_byte && i == len - 1)
        send_item(shs_pkg::CMD_ABSORB_FIN, 8'($urandom_range(0, 255)));
      else
        send_item(shs_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
    end
    if (!fin_on_byte)
      send_item(shs_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int edge_lens [10];
    int len;
    int pick;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty message, ignored command, single bytes at both extremes, "abc"
    send_item(shs_pkg::CMD_FINISH, 8'h00);
    send_item(CMD_UNUSED, 8'hff);
    send_item(shs_pkg::CMD_ABSORB_FIN, 8'h00);
    send_item(shs_pkg::CMD_ABSORB_FIN, 8'hff);
    send_item(shs_pkg::CMD_ABSORB, 8'h61);
    send_item(shs_pkg::CMD_ABSORB, 8'h62);
    send_item(shs_pkg::CMD_ABSORB_FIN, 8'h63);
    // ignored command mid message, finish carrying a byte that must be dropped
    send_item(shs_pkg::CMD_ABSORB, 8'h55);
    send_item(CMD_UNUSED, 8'h3c);
    send_item(shs_pkg::CMD_ABSORB, 8'haa);
    send_item(shs_pkg::CMD_FINISH, 8'hc3);
    send_item(shs_pkg::CMD_FINISH, 8'hff);

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        pressure_go <= 1'b1;
      end else if (items_sent >= RANDOM_ITEMS / 3) begin
        tx_idle_pct <= 65;
        rx_idle_pct <= 14;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)
        len = $urandom_range(0, 12);
      else if (pick < 85)
        len = edge_lens[$urandom_range(0, 9)];
      else
        len = $urandom_range(13, 100);
      send_message(len);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items over %0d messages, including padding edges and empty messages",
             items_sent, messages_sent);
    $display("checked %0d digest words of %0d predicted digests, %0d mismatches",
             sb.words_checked, sb.digests_predicted, sb.errors);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
